>>> rtl/utf8_repair_latin1_fallback_top_assert.svh
// assertion macros for the utf8 repair block
`ifndef UTF8_REPAIR_LATIN1_FALLBACK_TOP_ASSERT_SVH
`define UTF8_REPAIR_LATIN1_FALLBACK_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define UTF8R_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8R_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/utf8r_pkg.sv
// shared types, byte classes and sequence checks for the utf8 repair block
package utf8r_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } t_cls;

    typedef enum logic {
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // item as it sits in the queue between front and back
    typedef struct packed {
        logic [7:0] in_byte;
        t_cls       cls;
        logic       stream_end;
    } t_qitem;

    // one held byte of the decode window
    typedef struct packed {
        logic [7:0] b;
        t_cls       cls;
    } t_went;

    typedef struct packed {
        logic [2:0] win_cnt;
        logic       busy;
    } t_bstat;

    localparam logic [7:0]  LEAD2_MIN = 8'hC2;
    localparam logic [7:0]  LEAD3_MIN = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN = 8'hF0;
    localparam logic [7:0]  BAD_MIN   = 8'hF8;
    localparam logic [7:0]  CONT_MIN  = 8'h80;
    localparam logic [7:0]  CONT_END  = 8'hC0;
    localparam logic [15:0] CP3_MIN   = 16'h0800;
    localparam logic [20:0] CP4_MIN   = 21'h010000;
    localparam logic [20:0] CP4_END   = 21'h110000;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        if (b < CONT_MIN) begin
            c = CLS_ASCII;
        end else if (b < CONT_END) begin
            c = CLS_CONT;
        end else if (b < LEAD2_MIN) begin
            c = CLS_BAD;
        end else if (b < LEAD3_MIN) begin
            c = CLS_LEAD2;
        end else if (b < LEAD4_MIN) begin
            c = CLS_LEAD3;
        end else if (b < BAD_MIN) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

    // bytes a lead needs, zero for a byte that cannot start a sequence
    function automatic logic [2:0] need_of(input t_cls c);
        logic [2:0] n;
        case (c)
            CLS_ASCII: n = 3'd1;
            CLS_LEAD2: n = 3'd2;
            CLS_LEAD3: n = 3'd3;
            CLS_LEAD4: n = 3'd4;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // well-formedness of a complete sequence starting at w0
    function automatic logic seq_ok(input logic [2:0] need, input t_went w0,
                                    input t_went w1, input t_went w2, input t_went w3);
        logic [15:0] cp3;
        logic [20:0] cp4;
        logic        ok;
        cp3 = {w0.b[3:0], w1.b[5:0], w2.b[5:0]};
        cp4 = {w0.b[2:0], w1.b[5:0], w2.b[5:0], w3.b[5:0]};
        case (need)
            3'd1: ok = 1'b1;
            3'd2: ok = (w1.cls == CLS_CONT);
            3'd3: ok = (w1.cls == CLS_CONT) && (w2.cls == CLS_CONT) && (cp3 >= CP3_MIN);
            3'd4: ok = (w1.cls == CLS_CONT) && (w2.cls == CLS_CONT)
                       && (w3.cls == CLS_CONT) && (cp4 >= CP4_MIN) && (cp4 < CP4_END);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/utf8r_front.sv
// input side: classifies each byte and holds it in a two-entry queue
module utf8r_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  utf8r_pkg::t_in_item i_in_data,
    output logic               o_q_valid,
    output utf8r_pkg::t_qitem  o_q_item,
    input  logic               i_q_pop
);

    utf8r_pkg::t_qitem r_q [2];
    logic              r_wp;
    logic              n_wp;
    logic              r_rp;
    logic              n_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              push;

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = ~r_wp;
        end
        if (i_q_pop) begin
            n_rp = ~r_rp;
        end
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{in_byte:    i_in_data.in_byte,
                           cls:        utf8r_pkg::classify(i_in_data.in_byte),
                           stream_end: i_in_data.stream_end};
        end
    end

endmodule

>>> rtl/utf8r_back.sv
// decode: holds the window, decides each sequence, then sends a byte per ready cycle
module utf8r_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  utf8r_pkg::t_qitem    i_q_item,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output utf8r_pkg::t_out_item o_out_data,
    output utf8r_pkg::t_bstat    o_stat
);

    utf8r_pkg::t_state    r_state;
    utf8r_pkg::t_state    n_state;
    utf8r_pkg::t_went     r_w [4];
    utf8r_pkg::t_went     n_w [4];
    logic [2:0]           r_n;
    logic [2:0]           n_n;
    logic                 r_end;
    logic                 n_end;
    logic                 r_ok;
    logic                 n_ok;
    logic [2:0]           r_left;
    logic [2:0]           n_left;
    logic                 r_ov;
    logic                 n_ov;
    utf8r_pkg::t_out_item r_od;
    utf8r_pkg::t_out_item n_od;

    logic [2:0] need0;
    logic       hold;
    logic       ok0;
    logic       emit_fire;
    logic       fin;
    logic       last_next;
    logic [7:0] out_b;

    assign need0     = utf8r_pkg::need_of(r_w[0].cls);
    // window empty, or a lead still waiting for its continuation bytes
    assign hold      = (r_n == 3'd0) || ((need0 > r_n) && !r_end);
    assign ok0       = (need0 <= r_n) && utf8r_pkg::seq_ok(need0, r_w[0], r_w[1], r_w[2], r_w[3]);
    assign emit_fire = (r_state == utf8r_pkg::ST_EMIT) && (!r_ov || i_out_ready);
    assign fin       = (r_left == 3'd1);
    // after this shift nothing more comes out for the current item
    assign last_next = (r_n == 3'd1)
                       || ((utf8r_pkg::need_of(r_w[1].cls) > (r_n - 3'd1)) && !r_end);
    assign out_b     = r_ok ? r_w[0].b
                     : (fin ? {2'b10, r_w[0].b[5:0]} : {6'b110000, r_w[0].b[7:6]});

    assign o_q_pop     = (r_state == utf8r_pkg::ST_DECIDE) && hold && i_q_valid;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign o_stat      = '{win_cnt: r_n, busy: (r_state == utf8r_pkg::ST_EMIT)};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            utf8r_pkg::ST_DECIDE: begin
                if (!hold) begin
                    n_state = utf8r_pkg::ST_EMIT;
                end
            end
            utf8r_pkg::ST_EMIT: begin
                if (emit_fire && fin) begin
                    n_state = utf8r_pkg::ST_DECIDE;
                end
            end
            default: n_state = utf8r_pkg::ST_DECIDE;
        endcase
    end

    // window, decision and output register
    always_comb begin
        n_w    = r_w;
        n_n    = r_n;
        n_end  = r_end;
        n_ok   = r_ok;
        n_left = r_left;
        n_od   = r_od;
        n_ov   = r_ov;
        if (emit_fire) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
        if (o_q_pop) begin
            for (int i = 0; i < 4; i++) begin
                if (r_n[1:0] == i[1:0]) begin
                    n_w[i] = '{b: i_q_item.in_byte, cls: i_q_item.cls};
                end
            end
            n_n   = r_n + 3'd1;
            n_end = i_q_item.stream_end;
        end
        if ((r_state == utf8r_pkg::ST_DECIDE) && !hold) begin
            n_ok   = ok0;
            n_left = ok0 ? need0 : 3'd2;
        end
        if (emit_fire) begin
            n_od.out_byte    = out_b;
            n_od.run_last    = fin && last_next;
            n_od.stream_done = fin && last_next && r_end;
            n_left           = r_left - 3'd1;
            // good sequences drain a byte per transfer, a fallback byte after its pair
            if (r_ok || fin) begin
                for (int i = 0; i < 3; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_n = r_n - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utf8r_pkg::ST_DECIDE;
            r_n     <= 3'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_end  <= n_end;
        r_ok   <= n_ok;
        r_left <= n_left;
        r_od   <= n_od;
    end

endmodule

>>> rtl/utf8_repair_latin1_fallback_top.sv
// utf8 check and repair with latin-1 fallback: the last input byte of a completed sequence
// passes the input queue, window load, decide and output register before the first output byte
// throughput: bytes load into the window only in the decide state, and each decided sequence
// then emits its output bytes, so no new byte enters the window while a sequence is sent
// the decide/emit sequencer in the back end and its single output register set the rate
// synchronous active-low reset empties the queue, the window and the output register
module utf8_repair_latin1_fallback_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  utf8r_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output utf8r_pkg::t_out_item o_out_data
);

`include "utf8_repair_latin1_fallback_top_assert.svh"

    logic              q_valid;
    logic              q_pop;
    utf8r_pkg::t_qitem q_item;
    utf8r_pkg::t_bstat bstat;

    utf8r_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    utf8r_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_stat      (bstat)
    );

    `UTF8R_ASSERT_IMP(a_pop_has_item, q_pop, q_valid, "pop from empty queue")
    `UTF8R_ASSERT_IMP(a_win_bound, 1'b1, bstat.win_cnt <= 3'd4, "window overflow")
    `UTF8R_ASSERT_IMP(a_done_is_last, o_out_valid && o_out_data.stream_done,
                      o_out_data.run_last, "stream end byte not marked last of run")
    `UTF8R_ASSERT_NXT(a_pop_grows_window, q_pop && !bstat.busy,
                      bstat.win_cnt != 3'd0, "window empty right after a load")

endmodule
